### src/ima_adpcm_multichannel_decoder_top_macros.svh
// Assertion macros shared by the decoder RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef IMA_ADPCM_MULTICHANNEL_DECODER_TOP_MACROS_SVH
`define IMA_ADPCM_MULTICHANNEL_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define IMA_MCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IMA_MCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ima_mcd_pkg.sv
// Package for the multichannel IMA ADPCM decoder.
// Types, step-size table and index helpers; no dependencies.
`default_nettype none

package ima_mcd_pkg;

  localparam int unsigned MAX_CHANNELS   = 2;
  localparam int unsigned STEP_INDEX_MAX = 88;
  localparam int unsigned IDX_W          = 7;
  localparam int unsigned STEP_W         = 15;
  localparam int unsigned CFG_W          = 2;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       high_only;
  } byte_item_t;

  typedef struct packed {
    logic       valid;
    byte_item_t item;
  } q_head_t;

  localparam logic [STEP_W-1:0] STEP_TABLE [0:STEP_INDEX_MAX] = '{
    15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,    15'd13,    15'd14,
    15'd16,    15'd17,    15'd19,    15'd21,    15'd23,    15'd25,    15'd28,    15'd31,
    15'd34,    15'd37,    15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
    15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,   15'd130,   15'd143,
    15'd157,   15'd173,   15'd190,   15'd209,   15'd230,   15'd253,   15'd279,   15'd307,
    15'd337,   15'd371,   15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
    15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,  15'd1282,  15'd1411,
    15'd1552,  15'd1707,  15'd1878,  15'd2066,  15'd2272,  15'd2499,  15'd2749,  15'd3024,
    15'd3327,  15'd3660,  15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
    15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487, 15'd12635, 15'd13899,
    15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794,
    15'd32767
  };

  function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
    logic [STEP_W-1:0] s;
    if (idx > IDX_W'(STEP_INDEX_MAX)) begin
      s = STEP_TABLE[STEP_INDEX_MAX];
    end else begin
      s = STEP_TABLE[idx];
    end
    return s;
  endfunction

  // index update: codes 0..3 step down by one, 4..7 step up by 2,4,6,8; clamp 0..88
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx,
                                                  input logic [2:0] code);
    logic [IDX_W:0]   sum;
    logic [IDX_W-1:0] r;
    if (!code[2]) begin
      r = (idx == '0) ? '0 : idx - IDX_W'(1);
    end else begin
      sum = {1'b0, idx} + (IDX_W + 1)'({code[1:0], 1'b0}) + (IDX_W + 1)'(2);
      r   = (sum > (IDX_W + 1)'(STEP_INDEX_MAX)) ? IDX_W'(STEP_INDEX_MAX)
                                                 : sum[IDX_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/ima_mcd_in_if.sv
// Input channel: one encoded byte item per handshake.
// Depends on ima_mcd_pkg for nothing; plain valid/ready bundle.
`default_nettype none

interface ima_mcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       high_only;

  modport source (output valid, output code_byte, output high_only, input ready);
  modport sink   (input valid, input code_byte, input high_only, output ready);
endinterface

`default_nettype wire

### src/ima_mcd_out_if.sv
// Output channel: one decoded sample item per handshake.
// Plain valid/ready bundle, no dependencies.
`default_nettype none

interface ima_mcd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               channel;
  logic               last;

  modport source (output valid, output sample, output channel, output last, input ready);
  modport sink   (input valid, input sample, input channel, input last, output ready);
endinterface

`default_nettype wire

### src/ima_adpcm_multichannel_decoder_top.sv
// An accepted byte passes through the two-entry byte queue and then the output register; its high
// nibble is decoded first, then its low nibble unless the byte is high-only. Throughput is set by
// the single nibble decode unit that handles one nibble per cycle while the output is not stalled;
// the queue and the output register decouple input and output stalls.
// Reset: all predictors and step indexes zero, channel pointer zero, channel count 1,
// queue and output empty.
`default_nettype none

module ima_adpcm_multichannel_decoder_top (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ima_mcd_pkg::CFG_W-1:0] cfg_wdata_i,
  ima_mcd_in_if.sink                   in_chan,
  ima_mcd_out_if.source                out_chan
);

  logic [ima_mcd_pkg::CFG_W-1:0] chan_count_q;
  ima_mcd_pkg::q_head_t          head;
  logic                          pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= ima_mcd_pkg::CFG_W'(1);
    end else if (cfg_we_i) begin
      chan_count_q <= cfg_wdata_i;
    end
  end

  ima_mcd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .head_o  (head),
    .pop_i   (pop)
  );

  ima_mcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chan_count_i (chan_count_q),
    .head_i       (head),
    .pop_o        (pop),
    .out_chan     (out_chan)
  );

endmodule

`default_nettype wire

### src/ima_mcd_front.sv
// Front end: accepts byte items into a two-entry queue for the decode back end.
// Depends on ima_mcd_pkg, ima_mcd_in_if and the assertion macro header.
`default_nettype none

module ima_mcd_front (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  ima_mcd_in_if.sink           in_chan,
  output ima_mcd_pkg::q_head_t head_o,
  input  wire                  pop_i
);

  `include "ima_adpcm_multichannel_decoder_top_macros.svh"

  ima_mcd_pkg::byte_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_chan.ready = (count_q != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + (push ? 2'd1 : 2'd0) - (pop ? 2'd1 : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].code_byte <= in_chan.code_byte;
      mem_q[wr_ptr_q].high_only <= in_chan.high_only;
    end
  end

  `IMA_MCD_ASSERT_IMP(a_count_bound, 1'b1, count_q <= 2'd2, "queue count overflow")
  `IMA_MCD_ASSERT_IMP(a_pop_nonempty, pop_i, count_q != 2'd0, "pop from empty queue")
  `IMA_MCD_ASSERT_NXT(a_push_count, push && !pop, count_q == $past(count_q) + 2'd1,
                      "queue count not advanced on push")

endmodule

`default_nettype wire

### src/ima_mcd_back.sv
// Back end: decodes one nibble per cycle unless the output stalls, on the shared step unit, per-channel state.
// Depends on ima_mcd_pkg, ima_mcd_out_if and the assertion macro header.
`default_nettype none

module ima_mcd_back (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire [ima_mcd_pkg::CFG_W-1:0]       chan_count_i,
  input  wire ima_mcd_pkg::q_head_t          head_i,
  output logic                               pop_o,
  ima_mcd_out_if.source                      out_chan
);

  `include "ima_adpcm_multichannel_decoder_top_macros.svh"

  localparam int unsigned MAX_CHANNELS = ima_mcd_pkg::MAX_CHANNELS;
  localparam int unsigned CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1) + 1;
  localparam int unsigned IDX_W = ima_mcd_pkg::IDX_W;
  localparam int unsigned STP_W = ima_mcd_pkg::STEP_W;

  logic signed [15:0]      pred_q [MAX_CHANNELS];
  logic        [IDX_W-1:0] idx_q  [MAX_CHANNELS];
  logic        [STP_W-1:0] step_q [MAX_CHANNELS];
  logic        [CH_W-1:0]  ptr_q, ptr_d;
  logic                    phase_q, phase_d;

  logic                    out_valid_q;
  logic signed [15:0]      out_sample_q;
  logic                    out_channel_q;
  logic                    out_last_q;

  logic        [CNT_W-1:0] n_eff, cfg_ext, ptr_ext, ch_ext, ch_inc;
  logic        [CH_W-1:0]  ch;
  logic        [3:0]       code;
  logic                    is_last, fire;
  logic        [STP_W-1:0] step;
  logic        [16:0]      mag;
  logic signed [17:0]      sum;
  logic signed [15:0]      pred_new;
  logic        [IDX_W-1:0] idx_new;

  always_comb begin
    cfg_ext = CNT_W'(chan_count_i);
    if (cfg_ext == '0) begin
      n_eff = CNT_W'(1);
    end else if (cfg_ext > CNT_W'(MAX_CHANNELS)) begin
      n_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      n_eff = cfg_ext;
    end
    ptr_ext = CNT_W'(ptr_q);
    ch_ext  = (ptr_ext >= n_eff) ? '0 : ptr_ext;
    ch      = ch_ext[CH_W-1:0];
    ch_inc  = ch_ext + CNT_W'(1);
    ptr_d   = (ch_inc >= n_eff) ? '0 : ch_inc[CH_W-1:0];

    code    = phase_q ? head_i.item.code_byte[3:0] : head_i.item.code_byte[7:4];
    is_last = phase_q || head_i.item.high_only;
    fire    = head_i.valid && (!out_valid_q || out_chan.ready);

    step = step_q[ch];
    mag  = 17'(step >> 3)
         + (code[2] ? 17'(step) : 17'd0)
         + (code[1] ? 17'(step >> 1) : 17'd0)
         + (code[0] ? 17'(step >> 2) : 17'd0);
    sum  = code[3] ? (18'(pred_q[ch]) - $signed({1'b0, mag}))
                   : (18'(pred_q[ch]) + $signed({1'b0, mag}));
    if (sum > 18'sd32767) begin
      pred_new = 16'sh7FFF;
    end else if (sum < -18'sd32768) begin
      pred_new = 16'sh8000;
    end else begin
      pred_new = sum[15:0];
    end
    idx_new = ima_mcd_pkg::next_index(idx_q[ch], code[2:0]);

    phase_d = fire ? !is_last : phase_q;
    pop_o   = fire && is_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        pred_q[i] <= '0;
        idx_q[i]  <= '0;
        step_q[i] <= ima_mcd_pkg::step_size('0);
      end
      ptr_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (fire) begin
        pred_q[ch]  <= pred_new;
        idx_q[ch]   <= idx_new;
        step_q[ch]  <= ima_mcd_pkg::step_size(idx_new);
        ptr_q       <= ptr_d;
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sample_q  <= pred_new;
      out_channel_q <= ch[0];
      out_last_q    <= is_last;
    end
  end

  assign out_chan.valid   = out_valid_q;
  assign out_chan.sample  = out_sample_q;
  assign out_chan.channel = out_channel_q;
  assign out_chan.last    = out_last_q;

  `IMA_MCD_ASSERT_IMP(a_idx_range, 1'b1, idx_q[ch] <= IDX_W'(ima_mcd_pkg::STEP_INDEX_MAX),
                      "step index out of range")
  `IMA_MCD_ASSERT_IMP(a_step_match, 1'b1, step_q[ch] == ima_mcd_pkg::step_size(idx_q[ch]),
                      "cached step disagrees with index")
  `IMA_MCD_ASSERT_IMP(a_phase_low, phase_q, head_i.valid && !head_i.item.high_only,
                      "low nibble pending without a full byte")

endmodule

`default_nettype wire
